>>> sv/rram_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rram_pkg
// Shared types and constants of the region rotate address map.
// ---------------------------------------------------------------------------
package rram_pkg;

	localparam int EdgeW  = 13;   // region edge registers
	localparam int CoordW = 12;   // pixel coordinates
	localparam int SumW   = 15;   // signed offsets within the turned block
	localparam int IdxW   = 3;    // configuration register index
	localparam int MaxDim = 4096; // largest edge value, larger ones saturate
	localparam int WhiteLevel = 255; // RGB value applied when force_white is set

	// Configuration register indexes
	localparam logic [IdxW-1:0] REG_LEFT   = 3'd0;
	localparam logic [IdxW-1:0] REG_TOP    = 3'd1;
	localparam logic [IdxW-1:0] REG_RIGHT  = 3'd2;
	localparam logic [IdxW-1:0] REG_BOTTOM = 3'd3;
	localparam logic [IdxW-1:0] REG_TURN   = 3'd4;

	// Turn codes: none, 90, 180 and 270 degrees
	typedef enum logic [1:0] {
		TURN_NONE = 2'd0,
		TURN_90   = 2'd1,
		TURN_180  = 2'd2,
		TURN_270  = 2'd3
	} turn_t;

	// Region settings after edge saturation
	typedef struct packed {
		logic [EdgeW-1:0] x1;
		logic [EdgeW-1:0] y1;
		logic [EdgeW-1:0] x2;
		logic [EdgeW-1:0] y2;
		turn_t            turn;
	} cfg_t;

	// Word handed from the front stages to the back stages
	typedef struct packed {
		logic [CoordW-1:0]      dx;
		logic [CoordW-1:0]      dy;
		logic [CoordW-1:0]      x1;
		logic [CoordW-1:0]      y1;
		logic [EdgeW-1:0]       lenx;
		logic [EdgeW-1:0]       leny;
		logic signed [SumW-1:0] bx;
		logic signed [SumW-1:0] by;
		logic [CoordW-1:0]      mx;
		logic [CoordW-1:0]      my;
		logic                   in_rect;
		turn_t                  mode;
	} front_t;

endpackage

>>> sv/region_rotate_address_map.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// region_rotate_address_map
// Inverse address map for turning an image rectangle by 90, 180 or 270 deg.
// ---------------------------------------------------------------------------
// The block takes one destination pixel address per clock and returns the
// source pixel to fetch and a flag that replaces the fetched RGB by white
// while keeping its alpha. Four register stages (input capture and region
// size, block placement, block offsets, source select) lie between address
// and result; every stage takes a new word each cycle, so busy is always low
// and the sustained rate is one word per clock. Results appear for one cycle
// with done high and cannot be held off. The user must write region edges and
// the turn code only while no word is in flight; the block does not enforce it.
module region_rotate_address_map import rram_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IdxW-1:0]   cfg_index,
	input  logic [EdgeW-1:0]  cfg_data,
	input  logic              start,
	output logic              busy,
	input  logic [CoordW-1:0] dest_col,
	input  logic [CoordW-1:0] dest_row,
	output logic              done,
	output logic [CoordW-1:0] src_col,
	output logic [CoordW-1:0] src_row,
	output logic              force_white
);

	cfg_t   cfg;
	logic   valid_s2;
	front_t word_s2;
	logic   accept;

	// Every stage advances each cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	rram_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rram_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.dest_col (dest_col),
		.dest_row (dest_row),
		.cfg      (cfg),
		.valid_s2 (valid_s2),
		.word_s2  (word_s2)
	);

	rram_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s2    (valid_s2),
		.word_s2     (word_s2),
		.done        (done),
		.src_col     (src_col),
		.src_row     (src_row),
		.force_white (force_white)
	);

endmodule

>>> sv/rram_cfg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rram_cfg
// Configuration register bank; presents the saturated region edges.
// ---------------------------------------------------------------------------
module rram_cfg import rram_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IdxW-1:0]  cfg_index,
	input  logic [EdgeW-1:0] cfg_data,
	output cfg_t             cfg
);

	logic [EdgeW-1:0] left_q;
	logic [EdgeW-1:0] top_q;
	logic [EdgeW-1:0] right_q;
	logic [EdgeW-1:0] bottom_q;
	turn_t            turn_q;

	// Clamp an edge to the image size
	function automatic logic [EdgeW-1:0] sat_edge(input logic [EdgeW-1:0] v);
		logic [EdgeW-1:0] lim;
		lim = EdgeW'(MaxDim);
		return (v > lim) ? lim : v;
	endfunction

	// Write one register per enabled cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			right_q  <= '0;
			bottom_q <= '0;
			turn_q   <= TURN_NONE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT:   left_q   <= cfg_data;
				REG_TOP:    top_q    <= cfg_data;
				REG_RIGHT:  right_q  <= cfg_data;
				REG_BOTTOM: bottom_q <= cfg_data;
				REG_TURN:   turn_q   <= turn_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// Saturated view of the region
	always_comb begin
		cfg.x1   = sat_edge(left_q);
		cfg.y1   = sat_edge(top_q);
		cfg.x2   = sat_edge(right_q);
		cfg.y2   = sat_edge(bottom_q);
		cfg.turn = turn_q;
	end

endmodule

>>> sv/rram_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rram_front
// Stages 1 and 2: capture the word, size the region, place the turned block.
// ---------------------------------------------------------------------------
module rram_front import rram_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [CoordW-1:0] dest_col,
	input  logic [CoordW-1:0] dest_row,
	input  cfg_t              cfg,
	output logic              valid_s2,
	output front_t            word_s2
);

	logic              valid_s1;
	logic [CoordW-1:0] dx_s1;
	logic [CoordW-1:0] dy_s1;
	logic [EdgeW-1:0]  x1_s1;
	logic [EdgeW-1:0]  y1_s1;
	logic [EdgeW-1:0]  x2_s1;
	logic [EdgeW-1:0]  y2_s1;
	logic [EdgeW-1:0]  lenx_s1;
	logic [EdgeW-1:0]  leny_s1;
	turn_t             mode_s1;

	logic                   region_ok;
	logic signed [SumW-1:0] bx_c;
	logic signed [SumW-1:0] by_c;
	logic                   inside_c;

	// Drop the turn where the region is inverted
	assign region_ok = (cfg.x2 >= cfg.x1) && (cfg.y2 >= cfg.y1);

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload: word, edges and region size
	always_ff @(posedge clk) begin
		if (in_valid) begin
			dx_s1   <= dest_col;
			dy_s1   <= dest_row;
			x1_s1   <= cfg.x1;
			y1_s1   <= cfg.y1;
			x2_s1   <= cfg.x2;
			y2_s1   <= cfg.y2;
			lenx_s1 <= cfg.x2 - cfg.x1;
			leny_s1 <= cfg.y2 - cfg.y1;
			mode_s1 <= region_ok ? cfg.turn : TURN_NONE;
		end
	end

	// Origin of the turned block, recentred on the region middle
	assign bx_c = $signed({2'b00, x2_s1}) - $signed({3'b000, lenx_s1[EdgeW-1:1]})
	            - $signed({3'b000, leny_s1[EdgeW-1:1]});
	assign by_c = $signed({2'b00, y2_s1}) - $signed({3'b000, leny_s1[EdgeW-1:1]})
	            - $signed({3'b000, lenx_s1[EdgeW-1:1]});

	// Test the word against the original rectangle
	assign inside_c = ({1'b0, dx_s1} >= x1_s1) && ({1'b0, dx_s1} < x2_s1)
	               && ({1'b0, dy_s1} >= y1_s1) && ({1'b0, dy_s1} < y2_s1);

	// Stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			word_s2.dx      <= dx_s1;
			word_s2.dy      <= dy_s1;
			word_s2.x1      <= x1_s1[CoordW-1:0];
			word_s2.y1      <= y1_s1[CoordW-1:0];
			word_s2.lenx    <= lenx_s1;
			word_s2.leny    <= leny_s1;
			word_s2.bx      <= bx_c;
			word_s2.by      <= by_c;
			word_s2.mx      <= x1_s1[CoordW-1:0] + x2_s1[CoordW-1:0] - CoordW'(1);
			word_s2.my      <= y1_s1[CoordW-1:0] + y2_s1[CoordW-1:0] - CoordW'(1);
			word_s2.in_rect <= inside_c;
			word_s2.mode    <= mode_s1;
		end
	end

endmodule

>>> sv/rram_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rram_back
// Stages 3 and 4: locate the word in the turned block and pick the source.
// ---------------------------------------------------------------------------
module rram_back import rram_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s2,
	input  front_t            word_s2,
	output logic              done,
	output logic [CoordW-1:0] src_col,
	output logic [CoordW-1:0] src_row,
	output logic              force_white
);

	logic                   valid_s3;
	logic signed [SumW-1:0] r_s3;
	logic signed [SumW-1:0] c_s3;
	logic                   covered_s3;
	logic [CoordW-1:0]      sx180_s3;
	logic [CoordW-1:0]      sy180_s3;
	logic [CoordW-1:0]      dx_s3;
	logic [CoordW-1:0]      dy_s3;
	logic [CoordW-1:0]      x1_s3;
	logic [CoordW-1:0]      y1_s3;
	logic [CoordW-1:0]      lenx_s3;
	logic [CoordW-1:0]      leny_s3;
	logic                   inside_s3;
	turn_t                  mode_s3;

	logic signed [SumW-1:0] r_c;
	logic signed [SumW-1:0] c_c;

	logic                   valid_s4;
	logic [CoordW-1:0]      sx_s4;
	logic [CoordW-1:0]      sy_s4;
	logic                   white_s4;

	logic [CoordW-1:0]      sx_c;
	logic [CoordW-1:0]      sy_c;
	logic                   white_c;

	// Row and column within the turned block
	assign r_c = $signed({3'b000, word_s2.dy}) - word_s2.by;
	assign c_c = $signed({3'b000, word_s2.dx}) - word_s2.bx;

	// Stage 3 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	// Stage 3 payload: block offsets, coverage and point mirror
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			r_s3       <= r_c;
			c_s3       <= c_c;
			covered_s3 <= !r_c[SumW-1] && (r_c < $signed({2'b00, word_s2.lenx}))
			           && !c_c[SumW-1] && (c_c < $signed({2'b00, word_s2.leny}));
			sx180_s3   <= word_s2.mx - word_s2.dx;
			sy180_s3   <= word_s2.my - word_s2.dy;
			dx_s3      <= word_s2.dx;
			dy_s3      <= word_s2.dy;
			x1_s3      <= word_s2.x1;
			y1_s3      <= word_s2.y1;
			lenx_s3    <= word_s2.lenx[CoordW-1:0];
			leny_s3    <= word_s2.leny[CoordW-1:0];
			inside_s3  <= word_s2.in_rect;
			mode_s3    <= word_s2.mode;
		end
	end

	// Select the source pixel; coordinates wrap to the output width
	always_comb begin
		sx_c    = dx_s3;
		sy_c    = dy_s3;
		white_c = 1'b0;
		case (mode_s3)
			TURN_180: begin
				if (inside_s3) begin
					sx_c = sx180_s3;
					sy_c = sy180_s3;
				end
			end
			TURN_90: begin
				if (covered_s3) begin
					sx_c = x1_s3 + r_s3[CoordW-1:0];
					sy_c = y1_s3 + leny_s3 - CoordW'(1) - c_s3[CoordW-1:0];
				end else if (inside_s3) begin
					white_c = 1'b1;
				end
			end
			TURN_270: begin
				if (covered_s3) begin
					sx_c = x1_s3 + lenx_s3 - CoordW'(1) - r_s3[CoordW-1:0];
					sy_c = y1_s3 + c_s3[CoordW-1:0];
				end else if (inside_s3) begin
					white_c = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Stage 4 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	// Stage 4 payload: result register
	always_ff @(posedge clk) begin
		if (valid_s3) begin
			sx_s4    <= sx_c;
			sy_s4    <= sy_c;
			white_s4 <= white_c;
		end
	end

	assign done        = valid_s4;
	assign src_col     = sx_s4;
	assign src_row     = sy_s4;
	assign force_white = white_s4;

	// A result leaves in the cycle after its word reached stage 3
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 == $past(valid_s3))
		else $error("result strobe out of step with stage 3");

	// Whitening only happens for quarter turns
	a_white_mode: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && (mode_s3 == TURN_NONE || mode_s3 == TURN_180) |=> !white_s4)
		else $error("force_white raised outside a quarter turn");

	// A whitened pixel fetches its own location
	a_white_self: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && white_s4 |-> (sx_s4 == $past(dx_s3)) && (sy_s4 == $past(dy_s3)))
		else $error("whitened pixel fetched from elsewhere");

	// A pixel outside the rectangle and the turned block maps to itself
	a_outside_identity: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !inside_s3 && !covered_s3 |=>
		!white_s4 && (sx_s4 == $past(dx_s3)) && (sy_s4 == $past(dy_s3)))
		else $error("pixel outside the region was moved");

endmodule
